FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL of the positional list engine.
// No dependencies; the bodies fall away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

FILE: rtl/ple_pkg.sv
// Package of the positional list engine: beat types, command and status codes,
// and the control word broadcast to the cell row. No dependencies.
`timescale 1ns / 1ps

package ple_pkg;

    // Widths that cover the largest supported capacity of 64 elements.
    localparam int IDX_W = 6;
    localparam int LEN_W = 7;

    localparam logic [2:0] CMD_INS_END   = 3'd0;
    localparam logic [2:0] CMD_INS_FRONT = 3'd1;
    localparam logic [2:0] CMD_INS_AT    = 3'd2;
    localparam logic [2:0] CMD_READ      = 3'd3;
    localparam logic [2:0] CMD_UPDATE    = 3'd4;
    localparam logic [2:0] CMD_DEL_FRONT = 3'd5;
    localparam logic [2:0] CMD_DEL_END   = 3'd6;
    localparam logic [2:0] CMD_DEL_AT    = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OOB   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [2:0] OP_HOLD   = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_UPDATE = 3'd3;
    localparam logic [2:0] OP_ROTATE = 3'd4;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [5:0]         position;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] item_value;
        logic [1:0]         status;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [2:0]       op;
        logic [IDX_W-1:0] idx;
        logic [LEN_W-1:0] len;
        logic [31:0]      value;
    } cell_ctrl_t;

endpackage

FILE: rtl/positional_list_engine_core.sv
// Positional list engine: an edit command is taken at accept and its status beat
// is in the output register on the next cycle. While the output takes them, edits
// can follow one per cycle and a read-out of N elements, once the state register is
// set to read, gives one beat per cycle; it holds off input until its final beat is
// loaded. Reset (rst_n low, asynchronous) clears the length and the control state;
// element contents are undefined until written and never read before.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module positional_list_engine_core #(
    parameter int CAPACITY = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ple_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ple_pkg::out_item_t out_data
);
    import ple_pkg::*;

    // Length holds 0..CAPACITY, one bit over an index for a power-of-two CAPACITY.
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = $clog2(CAPACITY);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic          state_reg;
    logic          state_next;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    out_item_t     out_data_reg;
    out_item_t     out_data_next;

    logic          accept;
    logic          out_free;
    logic          empty;
    logic          full;
    logic [7:0]    pos_w;
    logic [7:0]    len_w;
    logic [1:0]    cmd_status;
    logic [2:0]    cmd_op;
    logic [5:0]    cmd_idx;
    logic          cmd_read;
    logic          read_last;
    cell_ctrl_t    ctrl;

    logic [31:0]   cell_data [CAPACITY];

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    assign empty = (len_reg == '0);
    assign full  = (len_reg == LW'(CAPACITY));
    assign pos_w = 8'(in_data.position);
    assign len_w = 8'(len_reg);

    // Decode the command against the current length. The edit itself is handed
    // to the cell row as one operation with a 0-based index.
    always_comb
    begin
        cmd_status = ST_OK;
        cmd_op     = OP_HOLD;
        cmd_idx    = '0;
        cmd_read   = 1'b0;
        unique case (in_data.cmd)
            CMD_INS_END:
            begin
                if (full)
                    cmd_status = ST_FULL;
                else
                begin
                    cmd_op  = OP_INSERT;
                    cmd_idx = 6'(len_reg);
                end
            end
            CMD_INS_FRONT:
            begin
                if (full)
                    cmd_status = ST_FULL;
                else
                    cmd_op = OP_INSERT;
            end
            CMD_INS_AT:
            begin
                // The bounds check comes before the full check.
                if (pos_w == 8'd0 || pos_w > len_w + 8'd1)
                    cmd_status = ST_OOB;
                else if (full)
                    cmd_status = ST_FULL;
                else
                begin
                    cmd_op  = OP_INSERT;
                    cmd_idx = in_data.position - 6'd1;
                end
            end
            CMD_READ:
            begin
                if (empty)
                    cmd_status = ST_EMPTY;
                else
                    cmd_read = 1'b1;
            end
            CMD_UPDATE:
            begin
                if (empty)
                    cmd_status = ST_EMPTY;
                else if (pos_w == 8'd0 || pos_w > len_w)
                    cmd_status = ST_OOB;
                else
                begin
                    cmd_op  = OP_UPDATE;
                    cmd_idx = in_data.position - 6'd1;
                end
            end
            CMD_DEL_FRONT:
            begin
                if (empty)
                    cmd_status = ST_EMPTY;
                else
                    cmd_op = OP_DELETE;
            end
            CMD_DEL_END:
            begin
                if (empty)
                    cmd_status = ST_EMPTY;
                else
                begin
                    cmd_op  = OP_DELETE;
                    cmd_idx = 6'(len_reg - LW'(1));
                end
            end
            CMD_DEL_AT:
            begin
                if (empty)
                    cmd_status = ST_EMPTY;
                else if (pos_w == 8'd0 || pos_w > len_w)
                    cmd_status = ST_OOB;
                else
                begin
                    cmd_op  = OP_DELETE;
                    cmd_idx = in_data.position - 6'd1;
                end
            end
            default:
            begin
                cmd_status = ST_OK;
            end
        endcase
    end

    assign read_last = ((LW'(cnt_reg) + LW'(1)) == len_reg);

    // Sequencer: edits are applied at accept; a read-out steps the row once per
    // beat that the output register can take and always shows the head cell.
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        ctrl.op        = OP_HOLD;
        ctrl.idx       = cmd_idx;
        ctrl.len       = LEN_W'(len_reg);
        ctrl.value     = in_data.value;
        priority if (state_reg == S_READ)
        begin
            if (out_free)
            begin
                ctrl.op                  = OP_ROTATE;
                out_valid_next           = 1'b1;
                out_data_next.item_value = cell_data[0];
                out_data_next.status     = ST_OK;
                out_data_next.last       = read_last;
                if (read_last)
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + CW'(1);
            end
        end
        else if (accept)
        begin
            if (cmd_read)
            begin
                state_next = S_READ;
                cnt_next   = '0;
            end
            else
            begin
                ctrl.op                  = cmd_op;
                out_valid_next           = 1'b1;
                out_data_next.item_value = '0;
                out_data_next.status     = cmd_status;
                out_data_next.last       = 1'b1;
                if (cmd_op == OP_INSERT)
                    len_next = len_reg + LW'(1);
                else if (cmd_op == OP_DELETE)
                    len_next = len_reg - LW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The row of cells. Each cell sees its two neighbors and the head cell, which
    // wraps around during a read-out. The end cells reuse harmless inputs.
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [31:0] left_in;
        logic [31:0] right_in;

        if (k == 0)
        begin : g_first
            assign left_in = in_data.value;
        end
        else
        begin : g_mid_left
            assign left_in = cell_data[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_final
            assign right_in = cell_data[k];
        end
        else
        begin : g_mid_right
            assign right_in = cell_data[k+1];
        end

        ple_cell #(
            .INDEX(k)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .left_data  (left_in),
            .right_data (right_in),
            .head_data  (cell_data[0]),
            .data       (cell_data[k])
        );
    end

    `ASSERT_NEVER(a_len_bound, clk, rst_n, len_reg > LW'(CAPACITY), "list length over capacity")
    `ASSERT_PROP(a_read_blocks, clk, rst_n, (state_reg == S_READ) |-> !in_ready, "input taken during read-out")
    `ASSERT_PROP(a_cnt_bound, clk, rst_n, (state_reg == S_READ) |-> (LW'(cnt_reg) < len_reg), "read counter past length")
    `ASSERT_PROP(a_err_last, clk, rst_n, (out_valid_reg && out_data_reg.status != ST_OK) |-> out_data_reg.last, "error beat without last")
    `ASSERT_PROP(a_read_len_hold, clk, rst_n, (state_reg == S_READ) |=> (len_reg == $past(len_reg)), "length changed during read-out")

endmodule

FILE: rtl/ple_cell.sv
// One cell of the list row: holds the element at a fixed position and takes
// its next value from itself, a neighbor, the head cell or the broadcast value. Uses ple_pkg.
`timescale 1ns / 1ps

module ple_cell #(
    parameter int INDEX = 0
) (
    input  logic                clk,
    input  ple_pkg::cell_ctrl_t ctrl,
    input  logic [31:0]         left_data,
    input  logic [31:0]         right_data,
    input  logic [31:0]         head_data,
    output logic [31:0]         data
);
    import ple_pkg::*;

    localparam logic [LEN_W-1:0] POS     = LEN_W'(INDEX);
    localparam logic [LEN_W-1:0] POS_ONE = LEN_W'(INDEX + 1);

    logic [31:0]      data_reg;
    logic [31:0]      data_next;
    logic [LEN_W-1:0] idx_ext;

    assign idx_ext = LEN_W'(ctrl.idx);

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            OP_INSERT:
            begin
                if (POS > idx_ext)
                    data_next = left_data;
                else if (POS == idx_ext)
                    data_next = ctrl.value;
            end
            OP_DELETE:
            begin
                if (POS >= idx_ext)
                    data_next = right_data;
            end
            OP_UPDATE:
            begin
                if (POS == idx_ext)
                    data_next = ctrl.value;
            end
            OP_ROTATE:
            begin
                // The occupied part of the row turns left by one; the head
                // element wraps around to the last occupied cell.
                if (POS_ONE < ctrl.len)
                    data_next = right_data;
                else if (POS_ONE == ctrl.len)
                    data_next = head_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
